### design/tms_pkg.sv
// shared constants and types for the temporal median select block
`timescale 1ns / 1ps
`default_nettype none

package tms_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int PIX_W       = 8;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_W       = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } chain_ctrl_t;

endpackage

`default_nettype wire

### design/tms_cell.sv
// one sorted cell: holds one sample, inserts in order or shifts toward the head
`timescale 1ns / 1ps
`default_nettype none

module tms_cell
    import tms_pkg::*;
(
    input  wire logic             clk,
    input  wire chain_ctrl_t      ctrl,
    input  wire logic             occupied,
    input  wire logic [PIX_W-1:0] sample,
    input  wire logic             prev_gt,
    input  wire logic [PIX_W-1:0] prev_val,
    input  wire logic [PIX_W-1:0] next_val,
    output logic                  gt,
    output logic      [PIX_W-1:0] val
);

    logic [PIX_W-1:0] val_reg;
    logic [PIX_W-1:0] val_next;

    // new sample goes at or before this cell
    assign gt = !occupied || (sample < val_reg);

    always_comb
    begin
        val_next = val_reg;
        if (ctrl.insert && gt)
        begin
            val_next = prev_gt ? prev_val : sample;
        end
        else if (ctrl.shift)
        begin
            val_next = next_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

`default_nettype wire

### design/tms_chain.sv
// row of sorted cells for one color channel
`timescale 1ns / 1ps
`default_nettype none

module tms_chain
    import tms_pkg::*;
(
    input  wire logic             clk,
    input  wire chain_ctrl_t      ctrl,
    input  wire logic [CNT_W-1:0] count,
    input  wire logic [PIX_W-1:0] sample,
    output logic      [PIX_W-1:0] head
);

    logic [PIX_W-1:0] vals [MAX_SAMPLES];
    logic             gts  [MAX_SAMPLES];

    for (genvar i = 0; i < MAX_SAMPLES; i++)
    begin : g_cell
        logic             occ;
        logic             p_gt;
        logic [PIX_W-1:0] p_val;
        logic [PIX_W-1:0] n_val;

        assign occ = (count > CNT_W'(i));

        if (i == 0)
        begin : g_first
            assign p_gt  = 1'b0;
            assign p_val = '0;
        end
        else
        begin : g_mid
            assign p_gt  = gts[i-1];
            assign p_val = vals[i-1];
        end

        if (i == MAX_SAMPLES - 1)
        begin : g_last
            assign n_val = vals[i];
        end
        else
        begin : g_inner
            assign n_val = vals[i+1];
        end

        tms_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .occupied (occ),
            .sample   (sample),
            .prev_gt  (p_gt),
            .prev_val (p_val),
            .next_val (n_val),
            .gt       (gts[i]),
            .val      (vals[i])
        );
    end

    assign head = vals[0];

endmodule

`default_nettype wire

### design/temporal_median_select.sv
// top level: per-pixel temporal median of blue, green and red samples
//
// input stream: one word per frame for a single pixel position, tdata holds
// the blue, green and red bytes, tlast marks the final frame of the pixel.
// each channel keeps its samples sorted in a row of insertion cells, so
// frames are taken at one word per cycle while samples accumulate.
// after the word with tlast a readout follows: the cells shift toward the head
// until the upper middle sample sits in the head cell, and the median is picked
// off the head cell; s_tready is low during that readout.
// the result word shows on the output stream the cycle after readout ends,
// with tuser set if more than 64 samples arrived (extras are dropped).
// the result sits in an output register; a new pixel may start while it
// waits, and readout holds on its final cycle while the previous result
// is still not taken.
// reset clears the sample count, the overflow flag and the output valid;
// the sample cells themselves are not reset.
`timescale 1ns / 1ps
`default_nettype none

module temporal_median_select
    import tms_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // sample_blue, sample_green, sample_red
    input  wire logic        s_tlast,   // last_frame
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // median_blue, median_green, median_red
    output logic             m_tuser    // overflow
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             ovf_reg, ovf_next;
    logic             mval_reg, mval_next;
    logic [23:0]      mdata_reg;
    logic             muser_reg;
    logic [PIX_W-1:0] lo_reg [3];

    chain_ctrl_t      ctrl;
    logic [PIX_W-1:0] head [3];
    logic [PIX_W-1:0] med  [3];
    logic             full;
    logic             finish;
    logic             stall;
    logic [CNT_W-1:0] cnt_m1;
    logic [IDX_W-1:0] lo_idx;
    logic [IDX_W-1:0] hi_idx;

    assign full   = (count_reg == CNT_W'(MAX_SAMPLES));
    assign cnt_m1 = count_reg - CNT_W'(1);
    assign lo_idx = IDX_W'(cnt_m1 >> 1);
    assign hi_idx = IDX_W'(count_reg >> 1);
    assign stall  = mval_reg && !m_tready;

    tms_chain u_blue (
        .clk    (clk),
        .ctrl   (ctrl),
        .count  (count_reg),
        .sample (s_tdata[7:0]),
        .head   (head[0])
    );

    tms_chain u_green (
        .clk    (clk),
        .ctrl   (ctrl),
        .count  (count_reg),
        .sample (s_tdata[15:8]),
        .head   (head[1])
    );

    tms_chain u_red (
        .clk    (clk),
        .ctrl   (ctrl),
        .count  (count_reg),
        .sample (s_tdata[23:16]),
        .head   (head[2])
    );

    // median from the head cell, averaging with the lower middle for even counts
    for (genvar c = 0; c < 3; c++)
    begin : g_med
        logic [PIX_W:0] sum;
        assign sum    = {1'b0, lo_reg[c]} + {1'b0, head[c]} + (PIX_W+1)'(1);
        assign med[c] = count_reg[0] ? head[c] : sum[PIX_W:1];
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        k_next      = k_reg;
        ovf_next    = ovf_reg;
        ctrl.insert = 1'b0;
        ctrl.shift  = 1'b0;
        s_tready    = 1'b0;
        finish      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.insert = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                    end
                    if (s_tlast)
                    begin
                        state_next = ST_READ;
                        k_next     = '0;
                    end
                end
            end
            ST_READ:
            begin
                if (k_reg == hi_idx)
                begin
                    if (!stall)
                    begin
                        finish     = 1'b1;
                        state_next = ST_IDLE;
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                end
                else
                begin
                    ctrl.shift = 1'b1;
                    k_next     = k_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mval_next = mval_reg;
        if (finish)
        begin
            mval_next = 1'b1;
        end
        else if (m_tready)
        begin
            mval_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            k_reg     <= '0;
            ovf_reg   <= 1'b0;
            mval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            k_reg     <= k_next;
            ovf_reg   <= ovf_next;
            mval_reg  <= mval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ && k_reg == lo_idx)
        begin
            lo_reg[0] <= head[0];
            lo_reg[1] <= head[1];
            lo_reg[2] <= head[2];
        end
        if (finish)
        begin
            mdata_reg <= {med[2], med[1], med[0]};
            muser_reg <= ovf_reg;
        end
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

endmodule

`default_nettype wire

### dv/temporal_median_select_tb.sv
// testbench for the temporal median select block: directed and random pixels checked by a predictor
`timescale 1ns / 1ps

module temporal_median_select_tb
    import tms_pkg::*;
;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_WORDS = 720;
    localparam int IDLE_PCT     = 38;
    localparam int HOLD_OFF     = 300;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SHOW_LIMIT   = 10;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
        logic             last_frame;
    } frame_word_t;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
        logic             ovf;
    } median_word_t;

    typedef struct packed {
        frame_word_t  word;
        logic         has_want;
        median_word_t want;
    } script_row_t;

    typedef enum int {
        FILL_ANY,
        FILL_TIES,
        FILL_RAILS,
        FILL_LOW
    } fill_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;

    // sorted sample lanes: blue, green, red
    logic [PIX_W-1:0] lane [3][MAX_SAMPLES];
    int               stored  = 0;
    bit               dropped = 1'b0;
    median_word_t     medians_due [$];

    int errors     = 0;
    int cycles     = 0;
    bit quiet      = 1'b0;
    bit choke_req  = 1'b0;
    bit choke_done = 1'b0;

    script_row_t script [20] = '{
        '{'{0, 0, 0, 1}, 1, '{0, 0, 0, 0}},
        '{'{255, 255, 255, 1}, 1, '{255, 255, 255, 0}},
        '{'{0, 255, 128, 0}, 0, '{0, 0, 0, 0}},
        '{'{255, 0, 127, 1}, 1, '{128, 128, 128, 0}},
        '{'{254, 1, 0, 0}, 0, '{0, 0, 0, 0}},
        '{'{255, 2, 1, 1}, 1, '{255, 2, 1, 0}},
        '{'{10, 200, 7, 0}, 0, '{0, 0, 0, 0}},
        '{'{250, 3, 7, 0}, 0, '{0, 0, 0, 0}},
        '{'{11, 100, 255, 1}, 1, '{11, 100, 7, 0}},
        '{'{8'h55, 8'hAA, 8'h0F, 0}, 0, '{0, 0, 0, 0}},
        '{'{8'hAA, 8'h55, 8'hF0, 1}, 1, '{128, 128, 128, 0}},
        '{'{1, 2, 3, 0}, 0, '{0, 0, 0, 0}},
        '{'{2, 3, 4, 0}, 0, '{0, 0, 0, 0}},
        '{'{4, 5, 6, 0}, 0, '{0, 0, 0, 0}},
        '{'{3, 4, 5, 1}, 0, '{0, 0, 0, 0}},
        '{'{9, 9, 9, 0}, 0, '{0, 0, 0, 0}},
        '{'{5, 5, 5, 0}, 0, '{0, 0, 0, 0}},
        '{'{1, 1, 1, 0}, 0, '{0, 0, 0, 0}},
        '{'{0, 0, 0, 0}, 0, '{0, 0, 0, 0}},
        '{'{254, 254, 254, 1}, 0, '{0, 0, 0, 0}}
    };

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    temporal_median_select dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    function automatic void insert_lane(int ch, logic [PIX_W-1:0] v);
        int k;
        k = stored;
        while (k > 0 && lane[ch][k-1] > v)
        begin
            lane[ch][k] = lane[ch][k-1];
            k--;
        end
        lane[ch][k] = v;
    endfunction

    function automatic logic [PIX_W-1:0] lane_median(int ch);
        logic [PIX_W:0] sum;
        if (stored % 2 == 1)
            return lane[ch][stored / 2];
        sum = {1'b0, lane[ch][stored / 2 - 1]} + {1'b0, lane[ch][stored / 2]}
              + (PIX_W+1)'(1);
        return sum[PIX_W:1];
    endfunction

    function automatic bit track_frame(input frame_word_t w, output median_word_t m);
        m = '0;
        if (stored < MAX_SAMPLES)
        begin
            insert_lane(0, w.blue);
            insert_lane(1, w.green);
            insert_lane(2, w.red);
            stored++;
        end
        else
            dropped = 1'b1;
        if (!w.last_frame)
            return 1'b0;
        m.blue  = lane_median(0);
        m.green = lane_median(1);
        m.red   = lane_median(2);
        m.ovf   = dropped;
        stored  = 0;
        dropped = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [PIX_W-1:0] pick_byte(fill_t mode);
        case (mode)
            FILL_TIES:  return PIX_W'($urandom_range(100, 103));
            FILL_RAILS: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            FILL_LOW:   return PIX_W'($urandom_range(0, 7));
            default:    return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 8);
        if (r < 92)
            return $urandom_range(9, MAX_SAMPLES - 1);
        return $urandom_range(MAX_SAMPLES, MAX_SAMPLES + 16);
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_frame(input frame_word_t w, input bit has_want,
                              input median_word_t want);
        median_word_t m;
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {w.red, w.green, w.blue};
        s_tlast  <= w.last_frame;
        do
            @(posedge clk);
        while (!s_tready);
        if (track_frame(w, m))
            medians_due.insert(medians_due.size(), has_want ? want : m);
        @(negedge clk);
    endtask

    task automatic send_pixel(input int len);
        frame_word_t  w;
        median_word_t none;
        fill_t        mode;
        none = '0;
        mode = fill_t'($urandom_range(0, 5) > 3 ? $urandom_range(1, 3) : 0);
        for (int i = 0; i < len; i++)
        begin
            w.blue       = pick_byte(mode);
            w.green      = pick_byte(mode);
            w.red        = pick_byte(mode);
            w.last_frame = (i == len - 1);
            send_frame(w, 1'b0, none);
        end
    endtask

    initial
    begin
        int sent;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (script[i])
            send_frame(script[i].word, script[i].has_want, script[i].want);
        // store full just below, at and beyond the edge
        send_pixel(MAX_SAMPLES);
        send_pixel(MAX_SAMPLES + 1);
        send_pixel(MAX_SAMPLES - 1);
        send_pixel(MAX_SAMPLES + 8);
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            quiet = (sent >= 250 && sent < 400);
            if (sent >= 450)
                choke_req = 1'b1;
            begin
                int len;
                len = pick_len();
                send_pixel(len);
                sent += len;
            end
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;
        while (medians_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && medians_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // receiver side, with one long hold-off
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (choke_req && !choke_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF) @(negedge clk);
                choke_done = 1'b1;
            end
            else if (quiet)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin : watch_medians
        median_word_t want;
        bit           bad;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (medians_due.size() == 0)
            begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display("unexpected median word: tdata %h tuser %b", m_tdata, m_tuser);
            end
            else
            begin
                want = medians_due.pop_front();
                bad  = 1'b0;
                if (m_tdata[7:0] !== want.blue)
                    bad = 1'b1;
                if (m_tdata[15:8] !== want.green)
                    bad = 1'b1;
                if (m_tdata[23:16] !== want.red)
                    bad = 1'b1;
                if (m_tuser !== want.ovf)
                    bad = 1'b1;
                if (bad)
                begin
                    errors++;
                    if (errors <= SHOW_LIMIT)
                        $display("median mismatch: want b %0d g %0d r %0d ovf %0d, got b %0d g %0d r %0d ovf %0d",
                                 want.blue, want.green, want.red, want.ovf,
                                 m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tuser);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule
